// ===== design/i2cms_pkg.sv =====
// Package for the I2C master transfer sequencer.
// Holds the item types, the step state, the action and status codes and the counter width.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2cms_pkg;

  localparam int LEN_W = 16;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_WRITE   = 3'd2;
  localparam logic [2:0] ACT_RESTART = 3'd3;
  localparam logic [2:0] ACT_RX_ENT  = 3'd4;
  localparam logic [2:0] ACT_READ    = 3'd5;
  localparam logic [2:0] ACT_RESET   = 3'd6;

  localparam logic [2:0] STS_RUN   = 3'd0;
  localparam logic [2:0] STS_OK    = 3'd1;
  localparam logic [2:0] STS_NAK   = 3'd2;
  localparam logic [2:0] STS_ARB   = 3'd3;
  localparam logic [2:0] STS_BUS   = 3'd4;
  localparam logic [2:0] STS_UNEXP = 3'd5;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_EVENT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_ADDRESS = 3'd1,
    ST_COMMAND = 3'd2,
    ST_TX      = 3'd3,
    ST_RXADDR  = 3'd4,
    ST_SETRX   = 3'd5,
    ST_RX      = 3'd6
  } step_t;

  typedef struct packed {
    logic        req_type;
    logic [6:0]  slave_addr;
    logic [7:0]  reg_addr;
    logic        is_read;
    logic        is_register;
    logic [15:0] length;
    logic        arb_lost;
    logic        nak_seen;
    logic        bus_busy;
    logic        master_mode;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] out_byte;
    logic       set_no_ack;
    logic [7:0] rx_data;
    logic       issue_stop;
    logic       finished;
    logic [2:0] status_code;
  } res_item_t;

endpackage

`default_nettype wire

// ===== design/i2cms_in_reg.sv =====
// Input register stage of the I2C master transfer sequencer.
// Captures one input transaction; depends on i2cms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cms_in_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire logic                drain,
  input  wire i2cms_pkg::in_item_t item_in,
  output logic                     vld,
  output i2cms_pkg::in_item_t      item
);
  import i2cms_pkg::*;

  logic     vld_r, vld_nxt;
  in_item_t item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (drain) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_in;
    end
  end

  assign vld  = vld_r;
  assign item = item_r;

endmodule

`default_nettype wire

// ===== design/i2cms_seq_core.sv =====
// Transfer step logic: step state, byte counter and latched transfer setup.
// Computes one result per item in a single pass; depends on i2cms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cms_seq_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire i2cms_pkg::in_item_t item,
  output i2cms_pkg::res_item_t     res
);
  import i2cms_pkg::*;

  step_t             state_r, state_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic [6:0]        addr_r, addr_nxt;
  logic [7:0]        cmd_r, cmd_nxt;
  logic              rd_r, rd_nxt;
  logic              regf_r, regf_nxt;

  logic [LEN_W-1:0]  len_in;
  logic              nak;
  logic              bus_lost;
  step_t             eff;

  assign len_in   = LEN_W'(item.length);
  assign bus_lost = item.bus_busy && !item.master_mode;

  always_comb begin
    nak = item.nak_seen;
    if (state_r == ST_TX && left_r == '0) begin
      nak = 1'b0;
    end
    if (state_r == ST_RX && left_r == LEN_W'(1)) begin
      nak = 1'b0;
    end
  end

  // address phase resolves to its follow-on step in the same event
  always_comb begin
    eff = state_r;
    if (state_r == ST_ADDRESS) begin
      if (regf_r) begin
        eff = ST_COMMAND;
      end else if (rd_r) begin
        eff = ST_SETRX;
      end else begin
        eff = ST_TX;
      end
    end
  end

  // next state and counters
  always_comb begin
    state_nxt = state_r;
    left_nxt  = left_r;
    addr_nxt  = addr_r;
    cmd_nxt   = cmd_r;
    rd_nxt    = rd_r;
    regf_nxt  = regf_r;
    if (item.req_type == REQ_START) begin
      if (state_r == ST_IDLE) begin
        addr_nxt = item.slave_addr;
        cmd_nxt  = item.reg_addr;
        rd_nxt   = item.is_read;
        regf_nxt = item.is_register;
        left_nxt = len_in;
        if (!(item.is_read && len_in == '0)) begin
          state_nxt = ST_ADDRESS;
        end
      end
    end else if (state_r == ST_IDLE) begin
      state_nxt = ST_IDLE;
    end else if (item.arb_lost || nak) begin
      state_nxt = ST_IDLE;
    end else begin
      unique case (eff)
        ST_COMMAND: begin
          state_nxt = rd_r ? ST_RXADDR : ST_TX;
        end
        ST_TX: begin
          if (left_r != '0) begin
            left_nxt  = left_r - LEN_W'(1);
            state_nxt = ST_TX;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
        ST_RXADDR: begin
          state_nxt = bus_lost ? ST_IDLE : ST_SETRX;
        end
        ST_SETRX: begin
          state_nxt = ST_RX;
        end
        ST_RX: begin
          if (left_r <= LEN_W'(1)) begin
            left_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            left_nxt  = left_r - LEN_W'(1);
            state_nxt = ST_RX;
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  // result fields
  always_comb begin
    res = '0;
    if (item.req_type == REQ_START) begin
      if (state_r != ST_IDLE) begin
        res.status_code = STS_UNEXP;
      end else if (item.is_read && len_in == '0) begin
        res.finished    = 1'b1;
        res.status_code = STS_OK;
      end else begin
        res.action   = ACT_START;
        res.out_byte = {item.slave_addr, item.is_register ? 1'b0 : item.is_read};
      end
    end else if (state_r == ST_IDLE) begin
      res.status_code = STS_UNEXP;
    end else if (item.arb_lost) begin
      res.action      = ACT_RESET;
      res.finished    = 1'b1;
      res.status_code = STS_ARB;
    end else if (nak) begin
      res.issue_stop  = 1'b1;
      res.finished    = 1'b1;
      res.status_code = STS_NAK;
    end else begin
      unique case (eff)
        ST_COMMAND: begin
          res.action   = ACT_WRITE;
          res.out_byte = cmd_r;
        end
        ST_TX: begin
          if (left_r != '0) begin
            res.action   = ACT_WRITE;
            res.out_byte = item.tx_byte;
          end else begin
            res.issue_stop  = 1'b1;
            res.finished    = 1'b1;
            res.status_code = STS_OK;
          end
        end
        ST_RXADDR: begin
          if (bus_lost) begin
            res.finished    = 1'b1;
            res.status_code = STS_BUS;
          end else begin
            res.action   = ACT_RESTART;
            res.out_byte = {addr_r, 1'b1};
          end
        end
        ST_SETRX: begin
          res.action     = ACT_RX_ENT;
          res.set_no_ack = (left_r == LEN_W'(1));
        end
        ST_RX: begin
          res.action  = ACT_READ;
          res.rx_data = item.rx_byte;
          if (left_r <= LEN_W'(1)) begin
            res.issue_stop  = 1'b1;
            res.finished    = 1'b1;
            res.status_code = STS_OK;
          end else begin
            res.set_no_ack = (left_r == LEN_W'(2));
          end
        end
        default: begin
          res.status_code = STS_UNEXP;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      left_r  <= '0;
      addr_r  <= '0;
      cmd_r   <= '0;
      rd_r    <= 1'b0;
      regf_r  <= 1'b0;
    end else if (adv) begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
      addr_r  <= addr_nxt;
      cmd_r   <= cmd_nxt;
      rd_r    <= rd_nxt;
      regf_r  <= regf_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/i2cms_out_reg.sv =====
// Result register of the I2C master transfer sequencer.
// Holds one result transaction until taken; depends on i2cms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cms_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire logic                 take,
  input  wire i2cms_pkg::res_item_t res_in,
  output logic                      vld,
  output i2cms_pkg::res_item_t      res
);
  import i2cms_pkg::*;

  logic      vld_r, vld_nxt;
  res_item_t res_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign vld = vld_r;
  assign res = res_r;

endmodule

`default_nettype wire

// ===== design/i2c_master_transfer_sequencer_top.sv =====
// Top level of the I2C master transfer sequencer.
// Instantiates i2cms_in_reg, i2cms_seq_core and i2cms_out_reg; depends on i2cms_pkg.
//
//   channel | direction | tuser       | tdata
//   in_     | slave     | req_type    | setup, status and data bytes of one request
//   out_    | master    | action      | byte, flags and status of one controller step
//
// One request per cycle unless the result stalls; registered at input and at result.
// The step state and byte counter update as a request moves into the result register.
// A stalled result holds the input register; the input side keeps taking while it drains.
// Synchronous active-low reset empties both registers and returns the state to idle.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_transfer_sequencer_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // slave_addr[6:0] reg_addr[14:7] is_read[15] is_register[16] length[32:17]
  // arb_lost[33] nak_seen[34] bus_busy[35] master_mode[36] rx_byte[44:37]
  // tx_byte[52:45], zero pad above
  input  wire logic [i2cms_pkg::IN_TDATA_W-1:0]  in_tdata,
  // req_type[0]
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // out_byte[7:0] set_no_ack[8] rx_data[16:9] issue_stop[17] finished[18]
  // status_code[21:19], zero pad above
  output logic [i2cms_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // action[2:0]
  output logic [2:0]                             out_tuser
);
  import i2cms_pkg::*;

  in_item_t  in_item, cur_item;
  res_item_t res_comb, res_q;
  logic      cur_vld, adv, in_acc;

  assign in_item.req_type    = in_tuser;
  assign in_item.slave_addr  = in_tdata[6:0];
  assign in_item.reg_addr    = in_tdata[14:7];
  assign in_item.is_read     = in_tdata[15];
  assign in_item.is_register = in_tdata[16];
  assign in_item.length      = in_tdata[32:17];
  assign in_item.arb_lost    = in_tdata[33];
  assign in_item.nak_seen    = in_tdata[34];
  assign in_item.bus_busy    = in_tdata[35];
  assign in_item.master_mode = in_tdata[36];
  assign in_item.rx_byte     = in_tdata[44:37];
  assign in_item.tx_byte     = in_tdata[52:45];

  assign adv       = cur_vld && (!out_tvalid || out_tready);
  assign in_tready = !cur_vld || adv;
  assign in_acc    = in_tvalid && in_tready;

  i2cms_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (in_acc),
    .drain   (adv),
    .item_in (in_item),
    .vld     (cur_vld),
    .item    (cur_item)
  );

  i2cms_seq_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (cur_item),
    .res   (res_comb)
  );

  i2cms_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (adv),
    .take   (out_tready),
    .res_in (res_comb),
    .vld    (out_tvalid),
    .res    (res_q)
  );

  assign out_tuser = res_q.action;
  assign out_tdata = {2'b00, res_q.status_code, res_q.finished, res_q.issue_stop,
                      res_q.rx_data, res_q.set_no_ack, res_q.out_byte};

endmodule

`default_nettype wire

// ===== design/i2cms_checker.sv =====
// Port-level checks for the I2C master transfer sequencer, bound to the top level.
// Depends on i2cms_pkg and i2c_master_transfer_sequencer_top.
`timescale 1ns / 1ps
`default_nettype none

module i2cms_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [i2cms_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [2:0]                        out_tuser
);
  import i2cms_pkg::*;

  logic [2:0] sts;
  assign sts = out_tdata[21:19];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_stop_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17] |-> out_tdata[18] && (sts == STS_OK || sts == STS_NAK))
    else $error("stop without ok or nak completion");

  a_fin_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[18] |-> sts != STS_RUN && sts != STS_UNEXP)
    else $error("finished with running or unexpected status");

  a_read_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ACT_READ |-> sts == STS_RUN || sts == STS_OK)
    else $error("read byte delivered with error status");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind i2c_master_transfer_sequencer_top i2cms_checker u_i2cms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== verif/i2c_master_transfer_sequencer_top_test.sv =====
// Self-checking testbench for i2c_master_transfer_sequencer_top.
// Drives start and byte-complete requests, predicts each controller step in
// a local model and checks every result in order; depends on i2cms_pkg.
`timescale 1ns / 1ps

module i2c_master_transfer_sequencer_top_test;
  import i2cms_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_ITEMS  = 450;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [2:0]            out_tuser;

  i2c_master_transfer_sequencer_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // transfer model state
  step_t       seq_state = ST_IDLE;
  logic [15:0] seq_left  = '0;
  logic [6:0]  seq_addr  = '0;
  logic [7:0]  seq_cmd   = '0;
  logic        seq_rd    = 1'b0;
  logic        seq_rg    = 1'b0;

  res_item_t   pending_steps[$];
  in_item_t    seen_req;
  res_item_t   seen_step;
  res_item_t   want_step;

  int  n_err     = 0;
  int  n_sent    = 0;
  int  n_checked = 0;
  int  n_start   = 0;
  int  n_event   = 0;
  int  n_ok      = 0;
  int  n_nak     = 0;
  int  n_arb     = 0;
  int  n_bus     = 0;
  int  n_unexp   = 0;
  int  cyc_count = 0;
  int  hold_cycles = 0;
  bit  src_idle  = 1'b1;
  bit  sink_idle = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic res_item_t close_out(res_item_t r, logic [2:0] code, logic stop);
    r.issue_stop  = stop;
    r.finished    = 1'b1;
    r.status_code = code;
    seq_state     = ST_IDLE;
    return r;
  endfunction

  function automatic res_item_t sequence_step(in_item_t it);
    res_item_t r;
    logic      nak;
    r = '0;
    if (it.req_type == REQ_START) begin
      if (seq_state != ST_IDLE) begin
        r.status_code = STS_UNEXP;
        return r;
      end
      seq_addr = it.slave_addr;
      seq_cmd  = it.reg_addr;
      seq_rd   = it.is_read;
      seq_rg   = it.is_register;
      seq_left = it.length;
      if (seq_rd && seq_left == 16'd0) return close_out(r, STS_OK, 1'b0);
      r.action   = ACT_START;
      r.out_byte = {seq_addr, seq_rg ? 1'b0 : seq_rd};
      seq_state  = ST_ADDRESS;
      return r;
    end
    if (seq_state == ST_IDLE) begin
      r.status_code = STS_UNEXP;
      return r;
    end
    if (it.arb_lost) begin
      r.action = ACT_RESET;
      return close_out(r, STS_ARB, 1'b0);
    end
    nak = it.nak_seen;
    if (seq_state == ST_TX && seq_left == 16'd0) nak = 1'b0;
    if (seq_state == ST_RX && seq_left == 16'd1) nak = 1'b0;
    if (nak) return close_out(r, STS_NAK, 1'b1);
    if (seq_state == ST_ADDRESS) begin
      if (seq_rg) seq_state = ST_COMMAND;
      else if (seq_rd) seq_state = ST_SETRX;
      else seq_state = ST_TX;
    end
    case (seq_state)
      ST_COMMAND: begin
        r.action   = ACT_WRITE;
        r.out_byte = seq_cmd;
        if (seq_rd) seq_state = ST_RXADDR;
        else seq_state = ST_TX;
      end
      ST_TX: begin
        if (seq_left != 16'd0) begin
          r.action   = ACT_WRITE;
          r.out_byte = it.tx_byte;
          seq_left   = seq_left - 16'd1;
        end else begin
          r = close_out(r, STS_OK, 1'b1);
        end
      end
      ST_RXADDR: begin
        if (it.bus_busy && !it.master_mode) begin
          r = close_out(r, STS_BUS, 1'b0);
        end else begin
          r.action   = ACT_RESTART;
          r.out_byte = {seq_addr, 1'b1};
          seq_state  = ST_SETRX;
        end
      end
      ST_SETRX: begin
        r.action     = ACT_RX_ENT;
        r.set_no_ack = (seq_left == 16'd1);
        seq_state    = ST_RX;
      end
      default: begin
        r.action  = ACT_READ;
        r.rx_data = it.rx_byte;
        if (seq_left <= 16'd1) begin
          seq_left = '0;
          r = close_out(r, STS_OK, 1'b1);
        end else begin
          seq_left     = seq_left - 16'd1;
          r.set_no_ack = (seq_left == 16'd1);
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_req(in_item_t it);
    return {3'b000, it.tx_byte, it.rx_byte, it.master_mode, it.bus_busy, it.nak_seen,
            it.arb_lost, it.length, it.is_register, it.is_read, it.reg_addr, it.slave_addr};
  endfunction

  function automatic in_item_t start_req(logic [6:0] addr, logic [7:0] regb, logic rd,
                                         logic rg, logic [15:0] len);
    in_item_t it;
    it.req_type    = REQ_START;
    it.slave_addr  = addr;
    it.reg_addr    = regb;
    it.is_read     = rd;
    it.is_register = rg;
    it.length      = len;
    it.arb_lost    = 1'($urandom_range(0, 1));
    it.nak_seen    = 1'($urandom_range(0, 1));
    it.bus_busy    = 1'($urandom_range(0, 1));
    it.master_mode = 1'($urandom_range(0, 1));
    it.rx_byte     = 8'($urandom_range(0, 255));
    it.tx_byte     = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic in_item_t evt_req(logic arb, logic nak, logic busy, logic mm,
                                       logic [7:0] rx, logic [7:0] tx);
    in_item_t it;
    it.req_type    = REQ_EVENT;
    it.slave_addr  = 7'($urandom_range(0, 127));
    it.reg_addr    = 8'($urandom_range(0, 255));
    it.is_read     = 1'($urandom_range(0, 1));
    it.is_register = 1'($urandom_range(0, 1));
    it.length      = 16'($urandom_range(0, 65535));
    it.arb_lost    = arb;
    it.nak_seen    = nak;
    it.bus_busy    = busy;
    it.master_mode = mm;
    it.rx_byte     = rx;
    it.tx_byte     = tx;
    return it;
  endfunction

  function automatic in_item_t rand_event();
    logic busy;
    busy = 1'($urandom_range(0, 1));
    return evt_req($urandom_range(0, 29) == 0, $urandom_range(0, 19) == 0, busy,
                   busy ? ($urandom_range(0, 5) != 0) : 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endfunction

  function automatic logic [15:0] pick_length();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 16'($urandom_range(0, 5));
    if (sel < 9) return 16'($urandom_range(6, 20));
    if ($urandom_range(0, 1)) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic report_mismatch(string msg);
    if (n_err < 50) $display("MISMATCH cycle %0d: %s", cyc_count, msg);
    n_err++;
  endtask

  task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %h want %h", n_checked, name, got, want));
  endtask

  task automatic send_req(in_item_t it);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_req(it);
    in_tuser  <= it.req_type;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
  endtask

  // one transfer: start, then the events a clean transfer takes (one extra for a write), with stray
  // starts, aborts and long transfers cut short by an arbitration loss
  task automatic run_transfer();
    in_item_t it;
    int       len;
    int       nev;
    bit       capped;
    it = start_req(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_length());
    send_req(it);
    len = int'(it.length);
    if (it.is_read && len == 0) nev = 0;
    else if (!it.is_read) nev = (it.is_register ? 3 : 2) + len;
    else nev = (it.is_register ? 3 : 1) + len;
    capped = (nev > 12);
    if (capped) nev = 12;
    for (int k = 0; k < nev; k++) begin
      if ($urandom_range(0, 19) == 0) send_req(start_req(7'($urandom_range(0, 127)),
          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
          pick_length()));
      send_req(rand_event());
    end
    if (capped) send_req(evt_req(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255))));
    if ($urandom_range(0, 14) == 0) send_req(rand_event());
  endtask

  task automatic test_directed();
    send_req(evt_req(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF));
    send_req(start_req(7'h7F, 8'h00, 1'b0, 1'b0, 16'd2));
    send_req(evt_req(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00));
    send_req(evt_req(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'hFF));
    send_req(evt_req(1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 8'h3C));
    send_req(start_req(7'h00, 8'hFF, 1'b1, 1'b1, 16'd1));
    send_req(start_req(7'h11, 8'h22, 1'b0, 1'b0, 16'd3));
    send_req(evt_req(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00));
    send_req(evt_req(1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 8'h00));
    send_req(evt_req(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00));
    send_req(evt_req(1'b0, 1'b1, 1'b0, 1'b1, 8'hA5, 8'h00));
    send_req(start_req(7'h33, 8'h44, 1'b1, 1'b0, 16'd0));
    send_req(start_req(7'h55, 8'h00, 1'b1, 1'b0, 16'd3));
    send_req(evt_req(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00));
    send_req(evt_req(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00));
    send_req(evt_req(1'b0, 1'b0, 1'b0, 1'b0, 8'hFF, 8'h00));
    send_req(evt_req(1'b0, 1'b0, 1'b0, 1'b0, 8'h5A, 8'h00));
    send_req(start_req(7'h2A, 8'h80, 1'b0, 1'b1, 16'hFFFF));
    send_req(evt_req(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00));
    send_req(evt_req(1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 8'h00));
    send_req(start_req(7'h15, 8'h01, 1'b1, 1'b1, 16'd4));
    send_req(evt_req(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00));
    send_req(evt_req(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00));
    send_req(start_req(7'h6B, 8'h00, 1'b0, 1'b0, 16'd1));
    send_req(evt_req(1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00));
    send_req(evt_req(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00));
    wait_drained();
  endtask

  task automatic test_random();
    int goal;
    goal = n_sent + RAND_ITEMS;
    while (n_sent < goal) run_transfer();
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_cycles = 150;
    repeat (4) run_transfer();
    wait_drained();
  endtask

  task automatic test_steady();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    repeat (15) run_transfer();
    wait_drained();
  endtask

  // receiver side
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (sink_idle && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // predict on every accepted request
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      seen_req             = '0;
      seen_req.req_type    = in_tuser;
      seen_req.slave_addr  = in_tdata[6:0];
      seen_req.reg_addr    = in_tdata[14:7];
      seen_req.is_read     = in_tdata[15];
      seen_req.is_register = in_tdata[16];
      seen_req.length      = in_tdata[32:17];
      seen_req.arb_lost    = in_tdata[33];
      seen_req.nak_seen    = in_tdata[34];
      seen_req.bus_busy    = in_tdata[35];
      seen_req.master_mode = in_tdata[36];
      seen_req.rx_byte     = in_tdata[44:37];
      seen_req.tx_byte     = in_tdata[52:45];
      if (seen_req.req_type == REQ_START) n_start++;
      else n_event++;
      seen_step = sequence_step(seen_req);
      case (seen_step.status_code)
        STS_OK:    n_ok++;
        STS_NAK:   n_nak++;
        STS_ARB:   n_arb++;
        STS_BUS:   n_bus++;
        STS_UNEXP: n_unexp++;
        default: ;
      endcase
      pending_steps.push_back(seen_step);
    end
  end

  // check every accepted result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_steps.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: action %h tdata %h",
                                  out_tuser, out_tdata));
      end else begin
        want_step = pending_steps.pop_front();
        compare_field("action", 8'(out_tuser), 8'(want_step.action));
        compare_field("out_byte", out_tdata[7:0], want_step.out_byte);
        compare_field("set_no_ack", 8'(out_tdata[8]), 8'(want_step.set_no_ack));
        compare_field("rx_data", out_tdata[16:9], want_step.rx_data);
        compare_field("issue_stop", 8'(out_tdata[17]), 8'(want_step.issue_stop));
        compare_field("finished", 8'(out_tdata[18]), 8'(want_step.finished));
        compare_field("status_code", 8'(out_tdata[21:19]), 8'(want_step.status_code));
      end
      n_checked++;
    end
  end

  initial begin
    while (cyc_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc_count++;
    end
    $display("Timeout after %0d cycles, %0d results pending", cyc_count, pending_steps.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    test_steady();
    repeat (8) @(posedge clk);
    if (pending_steps.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived", pending_steps.size()));
    $display("Sent %0d requests (%0d starts, %0d byte events), checked %0d results",
             n_sent, n_start, n_event, n_checked);
    $display("Outcomes: ok %0d, nak %0d, arb lost %0d, bus lost %0d, unexpected %0d",
             n_ok, n_nak, n_arb, n_bus, n_unexp);
    if (n_err == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", n_err);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
